// ===== design/bepc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bepc_pkg;

   // Largest frame dimension supported by default
   localparam int MAX_DIM_DEFAULT = 4096;

   // Register and result field widths
   localparam int CFG_WIDTH       = 13;
   localparam int OUT_WIDTH       = 12;
   localparam int PIXEL_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 1;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_HEIGHT = 1'd1;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;

   // Per-pixel control passed to the point tracker
   typedef struct packed {
      logic advance;    // a pixel transfer happens this cycle
      logic frame_end;  // that pixel is the last of the frame
   } step_type;

endpackage

`default_nettype wire

// ===== design/bepc_position.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bepc_position #(
   parameter int MAX_DIM = bepc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [bepc_pkg::CFG_WIDTH-1:0] frame_width,
   input  wire logic [bepc_pkg::CFG_WIDTH-1:0] frame_height,
   output logic      [$clog2(MAX_DIM)-1:0]     row,
   output logic      [$clog2(MAX_DIM)-1:0]     col,
   output logic                                frame_end
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int MW = $clog2(MAX_DIM + 1);
   localparam int DW = (MW > bepc_pkg::CFG_WIDTH) ? MW : bepc_pkg::CFG_WIDTH;
   localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIM);

   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [DW-1:0] width_eff, height_eff;
   logic [DW-1:0] frame_width_ext, frame_height_ext;
   logic [DW-1:0] col_next, row_next;
   logic          row_wrap;

   // Clamp dimensions: zero acts as one, oversize acts as the maximum
   assign frame_width_ext  = DW'(frame_width);
   assign frame_height_ext = DW'(frame_height);

   always_comb begin
      if (frame_width_ext == '0) begin
         width_eff = DW'(1);
      end else if (frame_width_ext > DIM_MAX) begin
         width_eff = DIM_MAX;
      end else begin
         width_eff = frame_width_ext;
      end
      if (frame_height_ext == '0) begin
         height_eff = DW'(1);
      end else if (frame_height_ext > DIM_MAX) begin
         height_eff = DIM_MAX;
      end else begin
         height_eff = frame_height_ext;
      end
   end

   // Row and frame boundaries for the pixel at the current position
   assign col_next  = DW'(col_ff) + DW'(1);
   assign row_wrap  = (col_next >= width_eff);
   assign row_next  = DW'(row_ff) + DW'(row_wrap);
   assign frame_end = (row_next >= height_eff);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (advance) begin
         if (frame_end) begin
            row_in = '0;
            col_in = '0;
         end else if (row_wrap) begin
            row_in = row_next[CW-1:0];
            col_in = '0;
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;

endmodule

`default_nettype wire

// ===== design/bepc_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bepc_tracker #(
   parameter int MAX_DIM = bepc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bepc_pkg::step_type             step,
   input  wire logic                           foreground,
   input  wire logic [$clog2(MAX_DIM)-1:0]     row,
   input  wire logic [$clog2(MAX_DIM)-1:0]     col,
   output logic      [bepc_pkg::OUT_WIDTH-1:0] center_row,
   output logic      [bepc_pkg::OUT_WIDTH-1:0] center_col,
   output logic                                found
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int SW = CW + 2;

   logic          any_seen_ff, any_seen_in;
   logic [CW-1:0] first_row_ff, first_row_in;
   logic [CW-1:0] first_col_ff, first_col_in;
   logic [CW-1:0] last_row_ff, last_row_in;
   logic [CW-1:0] last_col_ff, last_col_in;
   logic [CW-1:0] left_row_ff, left_row_in;
   logic [CW-1:0] left_col_ff, left_col_in;
   logic [CW-1:0] right_row_ff, right_row_in;
   logic [CW-1:0] right_col_ff, right_col_in;
   logic [SW-1:0] row_sum, col_sum;

   // Extreme point update for a foreground pixel
   always_comb begin
      any_seen_in  = any_seen_ff;
      first_row_in = first_row_ff;
      first_col_in = first_col_ff;
      last_row_in  = last_row_ff;
      last_col_in  = last_col_ff;
      left_row_in  = left_row_ff;
      left_col_in  = left_col_ff;
      right_row_in = right_row_ff;
      right_col_in = right_col_ff;
      if (step.advance && foreground) begin
         if (!any_seen_ff) begin
            // first foreground pixel seeds every point
            first_row_in = row;
            first_col_in = col;
            left_row_in  = row;
            left_col_in  = col;
            right_row_in = row;
            right_col_in = col;
            any_seen_in  = 1'b1;
         end else begin
            if (col <= left_col_ff) begin
               left_row_in = row;
               left_col_in = col;
            end
            if (col >= right_col_ff) begin
               right_row_in = row;
               right_col_in = col;
            end
         end
         last_row_in = row;
         last_col_in = col;
      end
   end

   // Mean of the four points, including the pixel now transferred
   assign row_sum = SW'(first_row_in) + SW'(last_row_in)
                  + SW'(left_row_in) + SW'(right_row_in);
   assign col_sum = SW'(first_col_in) + SW'(last_col_in)
                  + SW'(left_col_in) + SW'(right_col_in);

   always_comb begin
      if (any_seen_in) begin
         center_row = bepc_pkg::OUT_WIDTH'(row_sum[SW-1:2]);
         center_col = bepc_pkg::OUT_WIDTH'(col_sum[SW-1:2]);
      end else begin
         center_row = '0;
         center_col = '0;
      end
   end

   assign found = any_seen_in;

   // Seen flag restarts each frame; point registers are only read once it is set
   always_ff @(posedge clock) begin
      if (reset) begin
         any_seen_ff <= 1'b0;
      end else if (step.advance && step.frame_end) begin
         any_seen_ff <= 1'b0;
      end else begin
         any_seen_ff <= any_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      first_row_ff <= first_row_in;
      first_col_ff <= first_col_in;
      last_row_ff  <= last_row_in;
      last_col_ff  <= last_col_in;
      left_row_ff  <= left_row_in;
      left_col_ff  <= left_col_in;
      right_row_ff <= right_row_in;
      right_col_ff <= right_col_in;
   end

endmodule

`default_nettype wire

// ===== design/blob_extreme_point_center_core.sv =====
// The result is valid in the cycle after the transfer of the last pixel of a frame.
// Throughput: one pixel per cycle when not stalled; the pixel counters and point compares are combinational.
// The input stalls only when a frame-ending pixel arrives while the previous result is held.
// Reset (synchronous, active high) sets the frame size to 640 x 480, clears the position
// counters, the seen flag and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module blob_extreme_point_center_core #(
   parameter int MAX_DIM = bepc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [bepc_pkg::PIXEL_WIDTH-1:0]     req_pixel_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [bepc_pkg::OUT_WIDTH-1:0]       rsp_center_row,
   output logic      [bepc_pkg::OUT_WIDTH-1:0]       rsp_center_col,
   output logic                                      rsp_found,
   input  wire logic                                 csr_write_enable,
   input  wire logic [bepc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bepc_pkg::CFG_WIDTH-1:0]       csr_write_data
);

   localparam int CW = $clog2(MAX_DIM);

   logic [bepc_pkg::CFG_WIDTH-1:0] frame_width_ff, frame_height_ff;
   logic [CW-1:0]                  row, col;
   logic                           frame_end;
   logic                           req_transfer, rsp_transfer;
   bepc_pkg::step_type             step;
   logic [bepc_pkg::OUT_WIDTH-1:0] center_row, center_col;
   logic                           found;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bepc_pkg::OUT_WIDTH-1:0] center_row_ff, center_col_ff;
   logic                           found_ff;

   // Frame size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bepc_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bepc_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bepc_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            bepc_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Handshake: only a frame-ending pixel needs a free result register
   assign rsp_transfer = rsp_valid_ff && !rsp_stall;
   assign req_stall    = rsp_valid_ff && rsp_stall && frame_end;
   assign req_transfer = req_valid && !req_stall;

   assign step = '{advance: req_transfer, frame_end: frame_end};

   bepc_position #(
      .MAX_DIM (MAX_DIM)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_transfer),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .row          (row),
      .col          (col),
      .frame_end    (frame_end)
   );

   bepc_tracker #(
      .MAX_DIM (MAX_DIM)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .foreground (req_pixel_value != '0),
      .row        (row),
      .col        (col),
      .center_row (center_row),
      .center_col (center_col),
      .found      (found)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_transfer) begin
         rsp_valid_in = 1'b0;
      end
      if (req_transfer && frame_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer && frame_end) begin
         center_row_ff <= center_row;
         center_col_ff <= center_col;
         found_ff      <= found;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_row = center_row_ff;
   assign rsp_center_col = center_col_ff;
   assign rsp_found      = found_ff;

endmodule

`default_nettype wire
